// ===== src/fsa_pkg.sv =====
// Shared types and constants for the fragmented sparse array.
// Field widths, operation kinds, register indexes and FSM states.
// No dependencies.
`timescale 1ns / 1ps

package fsa_pkg;

    localparam int KIND_W    = 3;
    localparam int INDEX_W   = 10;
    localparam int KEY_W     = 32;
    localparam int GEOM_W    = 5;
    localparam int LIVE_W    = 9;
    localparam int ACTIVE_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [GEOM_W-1:0] FRAG_COUNT_RST = 5'd16;
    localparam logic [GEOM_W-1:0] CELLS_RST      = 5'd16;
    localparam logic [KEY_W-1:0]  MARKER_RST     = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER     = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET      = 3'd0,
        KIND_GET      = 3'd1,
        KIND_DELETE   = 3'd2,
        KIND_CONTAINS = 3'd3,
        KIND_IS_SET   = 3'd4,
        KIND_CLEAR    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SCAN,
        ST_WIPE,
        ST_CLEAR
    } state_t;

endpackage

// ===== src/fsa_locate.sv =====
// Index locator: range check against the configured capacity and split of
// the index into fragment and store slot by a short restoring division.
// Depends on fsa_pkg.
`timescale 1ns / 1ps

module fsa_locate
    import fsa_pkg::*;
#(
    parameter int MAX_FRAGMENTS          = 16,
    parameter int MAX_CELLS_PER_FRAGMENT = 16,
    localparam int DEPTH  = MAX_FRAGMENTS * MAX_CELLS_PER_FRAGMENT,
    localparam int FRAG_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1,
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic [GEOM_W-1:0]  fragment_count,
    input  logic [GEOM_W-1:0]  cells_per_fragment,
    input  logic [INDEX_W-1:0] index,
    output logic               ok,
    output logic [FRAG_W-1:0]  frag,
    output logic [SLOT_W-1:0]  slot
);

    localparam int DW = INDEX_W + FRAG_W;

    logic [GEOM_W-1:0]    nf;
    logic [GEOM_W-1:0]    nc;
    logic [2*GEOM_W-1:0]  capacity;
    logic [DW-1:0]        rem;
    logic [FRAG_W-1:0]    quo;
    logic [31:0]          slot_wide;

    // Saturate geometry to the store's dimensions
    assign nf = (32'(fragment_count) > MAX_FRAGMENTS) ? GEOM_W'(MAX_FRAGMENTS)
                                                      : fragment_count;
    assign nc = (32'(cells_per_fragment) > MAX_CELLS_PER_FRAGMENT)
                ? GEOM_W'(MAX_CELLS_PER_FRAGMENT) : cells_per_fragment;

    assign capacity = (2*GEOM_W)'(nf) * (2*GEOM_W)'(nc);
    assign ok = (nf != '0) && (nc != '0) && ((2*GEOM_W)'(index) < capacity);

    // Quotient is below the fragment count, so FRAG_W steps suffice
    always_comb
    begin
        logic [DW-1:0] trial;
        rem = DW'(index);
        quo = '0;
        for (int b = FRAG_W - 1; b >= 0; b--)
        begin
            trial = DW'(nc) << b;
            if (rem >= trial)
            begin
                rem    = rem - trial;
                quo[b] = 1'b1;
            end
        end
    end

    assign slot_wide = 32'(quo) * 32'(MAX_CELLS_PER_FRAGMENT) + 32'(rem);
    assign slot      = slot_wide[SLOT_W-1:0];
    assign frag      = quo;

endmodule

// ===== src/fragmented_sparse_array_top.sv =====
// Top level of the fragmented sparse array: control FSM, cell store memory
// with a valid bit per word, per-fragment live counts and configuration registers.
// Depends on fsa_pkg and fsa_locate.
`timescale 1ns / 1ps

// Usage (DEPTH = MAX_FRAGMENTS * MAX_CELLS_PER_FRAGMENT)
//   Command channel: an operation is taken at a clock edge where start is high
//   and busy is low. kind, index and key are sampled at that edge.
//   Result channel: done is high for exactly one cycle with status, value and
//   found; live_cells and active_fragments show the counts, which a clear or a
//   geometry write zeroes when it begins. The receiver cannot stall.
//   Configuration: cfg_valid/cfg_ready write channel with cfg_index and
//   cfg_data; cfg_ready is high while the block is idle and start is low.
//   Writing the fragment count or the cells per fragment empties the array.
// Operation flow
//   Set, get, delete, is-set and unknown kinds pass through a read state, which
//   reads the word, and an execute state, which acts on it and raises done;
//   start may be taken at the edge ending done.
//   Contains reads one word a cycle: done rises early on the first match, else
//   once the last word is compared. Clear rewrites every word: done rises as the
//   last word is written. A geometry write holds busy while every word is wiped.
// Reset
//   rst_n clears the counts, restores the register defaults and starts the same
//   clearing pass, so busy stays high after reset until every word is wiped.
module fragmented_sparse_array_top
    import fsa_pkg::*;
#(
    parameter int MAX_FRAGMENTS          = 16,
    parameter int MAX_CELLS_PER_FRAGMENT = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     kind,
    input  logic [INDEX_W-1:0]    index,
    input  logic signed [KEY_W-1:0] key,

    output logic                  done,
    output logic                  status,
    output logic signed [KEY_W-1:0] value,
    output logic                  found,
    output logic [LIVE_W-1:0]     live_cells,
    output logic [ACTIVE_W-1:0]   active_fragments,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_FRAGMENTS * MAX_CELLS_PER_FRAGMENT;
    localparam int FRAG_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_CELLS_PER_FRAGMENT + 1);
    localparam int TOT_W  = $clog2(DEPTH + 1);
    localparam int FA_W   = $clog2(MAX_FRAGMENTS + 1);

    // Configuration registers
    logic [GEOM_W-1:0] frag_count_reg;
    logic [GEOM_W-1:0] cells_reg;
    logic [KEY_W-1:0]  marker_reg;
    logic              cfg_fire;
    logic              cfg_clear;

    // Control and operation registers
    state_t            state_reg, state_next;
    kind_t             op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              ok_reg;
    logic [FRAG_W-1:0] frag_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TOT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;

    // Store: each word holds the valid bit above the cell value
    logic [KEY_W:0]    store_mem [DEPTH];
    logic [KEY_W:0]    rdata_reg;
    logic [SLOT_W-1:0] raddr;
    logic [SLOT_W-1:0] waddr;
    logic [KEY_W:0]    wdata;
    logic              mem_we;

    logic [CNT_W-1:0]  frag_cnt_reg [MAX_FRAGMENTS];
    logic [CNT_W-1:0]  frag_cnt_next [MAX_FRAGMENTS];
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [FA_W-1:0]   active_reg, active_next;

    // Result registers
    logic              done_reg, done_next;
    logic              status_reg, status_next;
    logic [KEY_W-1:0]  value_reg, value_next;
    logic              found_reg, found_next;

    // Locator outputs
    logic              loc_ok;
    logic [FRAG_W-1:0] loc_frag;
    logic [SLOT_W-1:0] loc_slot;

    logic              accept;
    logic              cell_valid;
    logic [CNT_W-1:0]  cur_cnt;
    logic              hit;
    logic              scan_last;
    logic              wipe_last;

    fsa_locate #(
        .MAX_FRAGMENTS          (MAX_FRAGMENTS),
        .MAX_CELLS_PER_FRAGMENT (MAX_CELLS_PER_FRAGMENT)
    ) u_locate (
        .fragment_count     (frag_count_reg),
        .cells_per_fragment (cells_reg),
        .index              (index),
        .ok                 (loc_ok),
        .frag               (loc_frag),
        .slot               (loc_slot)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign accept    = start && !busy;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_clear = cfg_fire && ((cfg_index == CFG_FRAG_COUNT) || (cfg_index == CFG_CELLS));

    assign cell_valid = rdata_reg[KEY_W];
    assign cur_cnt    = frag_cnt_reg[frag_reg];
    assign hit        = pend_reg && rdata_reg[KEY_W] && (rdata_reg[KEY_W-1:0] == key_reg);
    assign scan_last  = pend_reg && (scan_reg == TOT_W'(DEPTH));
    assign wipe_last  = (scan_reg == TOT_W'(DEPTH - 1));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_count_reg <= FRAG_COUNT_RST;
            cells_reg      <= CELLS_RST;
            marker_reg     <= MARKER_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_FRAG_COUNT: frag_count_reg <= cfg_data[GEOM_W-1:0];
                CFG_CELLS:      cells_reg      <= cfg_data[GEOM_W-1:0];
                CFG_MARKER:     marker_reg     <= cfg_data[KEY_W-1:0];
                default:        ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind_t'(kind) == KIND_CONTAINS)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (kind_t'(kind) == KIND_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
                else if (cfg_clear)
                begin
                    state_next = ST_WIPE;
                end
            end
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (hit || scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WIPE, ST_CLEAR:
            begin
                if (wipe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath actions per state
    always_comb
    begin
        frag_cnt_next = frag_cnt_reg;
        total_next    = total_reg;
        active_next   = active_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        value_next    = value_reg;
        found_next    = found_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        mem_we        = 1'b0;
        raddr         = slot_reg;
        waddr         = slot_reg;
        wdata         = {1'b1, key_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                scan_next = '0;
            end
            ST_READ: ;
            ST_EXEC:
            begin
                done_next   = 1'b1;
                status_next = 1'b0;
                value_next  = '0;
                found_next  = 1'b0;
                unique case (op_reg)
                    KIND_SET:
                    begin
                        if (!ok_reg)
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            if (!cell_valid)
                            begin
                                frag_cnt_next[frag_reg] = cur_cnt + CNT_W'(1);
                                total_next              = total_reg + TOT_W'(1);
                                if (cur_cnt == '0)
                                begin
                                    active_next = active_reg + FA_W'(1);
                                end
                            end
                        end
                    end
                    KIND_GET:
                    begin
                        status_next = !ok_reg;
                        value_next  = (ok_reg && cell_valid) ? rdata_reg[KEY_W-1:0]
                                                             : marker_reg;
                    end
                    KIND_DELETE:
                    begin
                        if (!ok_reg || !cell_valid)
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            mem_we                  = 1'b1;
                            wdata                   = {1'b0, rdata_reg[KEY_W-1:0]};
                            frag_cnt_next[frag_reg] = cur_cnt - CNT_W'(1);
                            total_next              = total_reg - TOT_W'(1);
                            if (cur_cnt == CNT_W'(1))
                            begin
                                active_next = active_reg - FA_W'(1);
                            end
                        end
                    end
                    KIND_IS_SET:
                    begin
                        status_next = !ok_reg;
                        found_next  = ok_reg && cell_valid;
                    end
                    default:
                    begin
                        status_next = 1'b1;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // Issue one read a cycle; compare the word read the cycle before
                raddr = scan_reg[SLOT_W-1:0];
                if (scan_reg != TOT_W'(DEPTH))
                begin
                    pend_next = 1'b1;
                    scan_next = scan_reg + TOT_W'(1);
                end
                if (hit || scan_last)
                begin
                    done_next   = 1'b1;
                    status_next = 1'b0;
                    value_next  = '0;
                    found_next  = hit;
                    pend_next   = 1'b0;
                end
            end
            ST_WIPE, ST_CLEAR:
            begin
                // Drop the valid bit of one word a cycle
                mem_we    = 1'b1;
                waddr     = scan_reg[SLOT_W-1:0];
                wdata     = '0;
                scan_next = scan_reg + TOT_W'(1);
                for (int f = 0; f < MAX_FRAGMENTS; f++)
                begin
                    frag_cnt_next[f] = '0;
                end
                total_next  = '0;
                active_next = '0;
                if ((state_reg == ST_CLEAR) && wipe_last)
                begin
                    done_next   = 1'b1;
                    status_next = 1'b0;
                    value_next  = '0;
                    found_next  = 1'b0;
                end
            end
            default: ;
        endcase

        // Geometry change empties the array
        if (cfg_clear)
        begin
            for (int f = 0; f < MAX_FRAGMENTS; f++)
            begin
                frag_cnt_next[f] = '0;
            end
            total_next  = '0;
            active_next = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_WIPE;
            total_reg  <= '0;
            active_reg <= '0;
            done_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            scan_reg   <= '0;
            for (int f = 0; f < MAX_FRAGMENTS; f++)
            begin
                frag_cnt_reg[f] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            active_reg    <= active_next;
            done_reg      <= done_next;
            pend_reg      <= pend_next;
            scan_reg      <= scan_next;
            frag_cnt_reg  <= frag_cnt_next;
        end
    end

    // Operation and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= kind_t'(kind);
            key_reg  <= key;
            ok_reg   <= loc_ok;
            frag_reg <= loc_frag;
            slot_reg <= loc_slot;
        end
        status_reg     <= status_next;
        value_reg      <= value_next;
        found_reg      <= found_next;
    end

    // Cell store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign value            = value_reg;
    assign found            = found_reg;
    assign live_cells       = LIVE_W'(total_reg);
    assign active_fragments = ACTIVE_W'(active_reg);

endmodule
